[rtl/nplc_pkg.sv]
`default_nettype none

package nplc_pkg;

	// defaults for the top-level parameters
	localparam int unsigned FRAC_BITS_DEF  = 16;
	localparam int unsigned COUNT_BITS_DEF = 48;

	// fixed field widths
	localparam int unsigned OUT_BITS   = 56;
	localparam int unsigned THR_BITS   = 48;
	localparam logic [THR_BITS-1:0] THR_RESET = 48'd65536;

	// log unit: squaring steps, ln(2) in Q.28, latency in cycles
	localparam int unsigned LN_STEPS = 28;
	localparam logic [27:0] LN2_Q28  = 28'd186065280;
	localparam int unsigned LN_LAT   = LN_STEPS + 4;

	// per-term magnitude cap is 2^TERM_CAP_LOG
	localparam int unsigned TERM_CAP_LOG = 60;

	// round a bit count up to whole bytes
	function automatic int byte_pad(input int n);
		return ((n + 7) >> 3) << 3;
	endfunction

	// width of the log result for an input of xw bits
	function automatic int ln_width(input int xw, input int fb);
		return $clog2(xw) + fb + 8;
	endfunction

endpackage

`default_nettype wire

[rtl/nplc_ln.sv]
`default_nettype none

module nplc_ln #(
	parameter int unsigned XW        = 49,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          en,
	input  logic [XW-1:0]                                 x,
	output logic [nplc_pkg::ln_width(XW, FRAC_BITS)-1:0] ln
);
	import nplc_pkg::*;

	localparam int EW  = $clog2(XW);
	localparam int LF  = FRAC_BITS + 8;
	localparam int MW  = 31;
	localparam int NW  = XW + MW;
	localparam int PW  = EW + LN_STEPS + 28;
	localparam int SH  = 56 - LF;

	logic [EW-1:0] e_c;
	logic [XW-1:0] x_s1;
	logic [EW-1:0] e_s1;
	logic          nz_s1;

	// leading one position
	always_comb begin
		e_c = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) begin
				e_c = EW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x;
			e_s1  <= e_c;
			nz_s1 <= |x;
		end
	end

	// normalise mantissa to q1.30
	logic [EW-1:0] sh_c;
	logic [NW-1:0] xw_c;
	logic [MW-1:0]     m_s   [0:LN_STEPS];
	logic [LN_STEPS-1:0] fr_s [0:LN_STEPS];
	logic [EW-1:0]     e_s   [0:LN_STEPS];
	logic              nz_s  [0:LN_STEPS];

	assign sh_c = EW'(XW - 1) - e_s1;
	assign xw_c = {x_s1, MW'(0)} << sh_c;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]  <= xw_c[NW-1 -: MW];
			fr_s[0] <= '0;
			e_s[0]  <= e_s1;
			nz_s[0] <= nz_s1;
		end
	end

	// one squaring per stage, one fraction bit out each
	for (genvar k = 0; k < LN_STEPS; k++) begin : g_sq
		logic [2*MW-1:0] sq;
		logic [MW:0]     mm;
		assign sq = (2*MW)'(m_s[k]) * (2*MW)'(m_s[k]);
		assign mm = sq[2*MW-1:MW-1];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k+1]  <= mm[MW] ? mm[MW:1] : mm[MW-1:0];
				fr_s[k+1] <= {fr_s[k][LN_STEPS-2:0], mm[MW]};
				e_s[k+1]  <= e_s[k];
				nz_s[k+1] <= nz_s[k];
			end
		end
	end

	// log2 to ln scaling
	logic [PW-1:0] p_s;
	logic          nzp_s;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s   <= PW'({e_s[LN_STEPS], fr_s[LN_STEPS]}) * PW'(LN2_Q28);
			nzp_s <= nz_s[LN_STEPS];
		end
	end

	// round half up to the log fraction
	logic [PW-1:0] pr_c;
	assign pr_c = p_s + (PW'(1) << (SH - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			ln <= nzp_s ? pr_c[PW-1:SH] : '0;
		end
	end

endmodule

`default_nettype wire

[rtl/ngram_prune_logprob_change.sv]
`default_nettype none

// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   word_count, state_discount, lower_count,
//                                              lower_total
// m_axis    out  m_axis_tvalid/m_axis_tready   ll_delta, prune, bad_input
// cfg       in   cfg_wr_en                     prune_threshold
//
// one item per cycle while no stall holds the pipeline; each item passes the input checks,
// the one-bit-per-stage divider, the 28-stage squaring log units and the product and
// summing stages before its result is offered
// arst_n clears the valid bits and the output valid and sets the threshold to 65536
// a stall holds every stage; bubbles let items in while a result waits

module ngram_prune_logprob_change #(
	parameter int unsigned FRAC_BITS  = nplc_pkg::FRAC_BITS_DEF,
	parameter int unsigned COUNT_BITS = nplc_pkg::COUNT_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         cfg_wr_en,
	input  logic [nplc_pkg::THR_BITS-1:0]                cfg_wr_data,
	input  logic                                         s_axis_tvalid,
	output logic                                         s_axis_tready,
	// word_count, state_discount, lower_count, lower_total
	input  logic [nplc_pkg::byte_pad(4*COUNT_BITS)-1:0]  s_axis_tdata,
	output logic                                         m_axis_tvalid,
	input  logic                                         m_axis_tready,
	// ll_delta, prune, bad_input
	output logic [nplc_pkg::byte_pad(nplc_pkg::OUT_BITS+2)-1:0] m_axis_tdata
);
	import nplc_pkg::*;

	localparam int CW   = COUNT_BITS;
	localparam int XW   = CW + 1;
	localparam int LF   = FRAC_BITS + 8;
	localparam int LNW  = ln_width(XW, FRAC_BITS);
	localparam int LSW  = LNW + 3;
	localparam int H    = CW / 2;
	localparam int NLO  = XW / 2;
	localparam int NHI  = XW - NLO;
	localparam int PW2  = XW + LSW + 1;
	localparam int QW   = PW2 - LF;
	localparam int EXW  = (QW > 62) ? QW : 62;
	localparam int TW   = TERM_CAP_LOG + 2;
	localparam int SW   = TW + 2;
	localparam int P    = CW + 44;
	localparam int ODW  = byte_pad(OUT_BITS + 2);

	localparam int LX_ND  = 0;
	localparam int LX_NBC = 1;
	localparam int LX_NBT = 2;
	localparam int LX_BT  = 3;
	localparam int LX_AUG = 4;
	localparam int LX_BC  = 5;
	localparam int LX_D   = 6;
	localparam int NLN    = 7;

	localparam logic [TW-2:0] CAPV = (TW-1)'(1) << TERM_CAP_LOG;

	typedef struct packed {
		logic [CW-1:0] c;
		logic [CW-1:0] d;
		logic [CW-1:0] bc;
		logic [CW-1:0] bt;
		logic          bad;
	} it_t;

	typedef struct packed {
		it_t           it;
		logic [CW-1:0] rem;
		logic [CW-1:0] nlo;
		logic [CW-1:0] q;
	} dv_t;

	typedef struct packed {
		logic [XW-1:0] aug;
		logic [CW-1:0] ao;
		logic [CW-1:0] bcnt;
		logic [CW-1:0] cc;
		logic          bcnz;
		logic          bad;
	} side_t;

	// threshold register
	logic [THR_BITS-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// pipeline advance and valid bits
	logic [P-1:0] vp_q;
	logic         en;
	logic         ov_q;
	logic         ol;

	assign en            = !vp_q[P-1] || !ov_q || m_axis_tready;
	assign ol            = !ov_q || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q <= '0;
		end else if (en) begin
			vp_q <= {vp_q[P-2:0], s_axis_tvalid};
		end
	end

	// input register and first precondition checks
	logic [CW-1:0]  c_in, d_in, bc_in, bt_in;
	logic [CW+6:0]  bt100, d99;
	it_t            in_s1;

	assign c_in  = s_axis_tdata[CW-1:0];
	assign d_in  = s_axis_tdata[2*CW-1:CW];
	assign bc_in = s_axis_tdata[3*CW-1:2*CW];
	assign bt_in = s_axis_tdata[4*CW-1:3*CW];
	assign bt100 = (CW+7)'(bt_in) * (CW+7)'(100);
	assign d99   = (CW+7)'(d_in) * (CW+7)'(99);

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1.c   <= c_in;
			in_s1.d   <= d_in;
			in_s1.bc  <= bc_in;
			in_s1.bt  <= bt_in;
			in_s1.bad <= (c_in == '0) || (d_in == '0) || (bt_in <= bc_in) || (bt100 < d99);
		end
	end

	// d * bc in two partial products
	it_t                 it_s2;
	logic [CW+H-1:0]     pplo_s2;
	logic [2*CW-H-1:0]   pphi_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			it_s2   <= in_s1;
			pplo_s2 <= (CW+H)'(in_s1.d) * (CW+H)'(in_s1.bc[H-1:0]);
			pphi_s2 <= (2*CW-H)'(in_s1.d) * (2*CW-H)'(in_s1.bc[CW-1:H]);
		end
	end

	// dividend assembly, then restoring division by bt, one bit a stage
	logic [2*CW-1:0] num_c;
	dv_t             dv_s [0:CW];

	assign num_c = (2*CW)'(pplo_s2) + ((2*CW)'(pphi_s2) << H);

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].it  <= it_s2;
			dv_s[0].rem <= num_c[2*CW-1:CW];
			dv_s[0].nlo <= num_c[CW-1:0];
			dv_s[0].q   <= '0;
		end
	end

	for (genvar k = 0; k < CW; k++) begin : g_div
		logic [CW:0] t;
		logic [CW:0] df;
		logic        ge;
		assign t  = {dv_s[k].rem, dv_s[k].nlo[CW-1]};
		assign df = t - {1'b0, dv_s[k].it.bt};
		assign ge = t >= {1'b0, dv_s[k].it.bt};
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1].it  <= dv_s[k].it;
				dv_s[k+1].rem <= ge ? df[CW-1:0] : t[CW-1:0];
				dv_s[k+1].nlo <= {dv_s[k].nlo[CW-2:0], 1'b0};
				dv_s[k+1].q   <= {dv_s[k].q[CW-2:0], ge};
			end
		end
	end

	// shares and the augmented sums
	logic [CW-1:0] d_s4, bc_s4, bt_s4, share_s4, bcnt_s4, bdiff_s4;
	logic [XW-1:0] aug_s4, nd_s4, nbc_s4, nbt_s4;
	logic          bad_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4     <= dv_s[CW].it.d;
			bc_s4    <= dv_s[CW].it.bc;
			bt_s4    <= dv_s[CW].it.bt;
			bad_s4   <= dv_s[CW].it.bad;
			share_s4 <= dv_s[CW].q;
			bcnt_s4  <= dv_s[CW].it.d - dv_s[CW].q - CW'(dv_s[CW].rem != '0);
			bdiff_s4 <= dv_s[CW].it.bt - dv_s[CW].it.bc;
			aug_s4   <= XW'(dv_s[CW].it.c) + XW'(dv_s[CW].q);
			nd_s4    <= XW'(dv_s[CW].it.d) + XW'(dv_s[CW].it.c);
			nbc_s4   <= XW'(dv_s[CW].it.bc) + XW'(dv_s[CW].it.c);
			nbt_s4   <= XW'(dv_s[CW].it.bt) + XW'(dv_s[CW].it.c);
		end
	end

	// phantom counts: clamp, or flag when too negative
	logic          ov1, ov2, bad1, bad2;
	logic [CW-1:0] x1, x2;

	assign ov1  = bcnt_s4 > bdiff_s4;
	assign ov2  = share_s4 > bc_s4;
	assign x1   = bcnt_s4 - bdiff_s4;
	assign x2   = share_s4 - bc_s4;
	assign bad1 = ov1 && ((CW+10)'(bt_s4) < (CW+10)'(x1) * (CW+10)'(1000));
	assign bad2 = ov2 && ((CW+10)'(bc_s4) < (CW+10)'(x2) * (CW+10)'(1000));

	logic [XW-1:0] lnx_s5 [NLN];
	side_t         sd_s   [0:LN_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			lnx_s5[LX_ND]  <= nd_s4;
			lnx_s5[LX_NBC] <= nbc_s4;
			lnx_s5[LX_NBT] <= nbt_s4;
			lnx_s5[LX_BT]  <= XW'(bt_s4);
			lnx_s5[LX_AUG] <= aug_s4;
			lnx_s5[LX_BC]  <= XW'(bc_s4);
			lnx_s5[LX_D]   <= XW'(d_s4);
			sd_s[0].aug    <= aug_s4;
			sd_s[0].ao     <= ov2 ? '0 : bc_s4 - share_s4;
			sd_s[0].bcnt   <= bcnt_s4;
			sd_s[0].cc     <= ov1 ? '0 : bdiff_s4 - bcnt_s4;
			sd_s[0].bcnz   <= bc_s4 != '0;
			sd_s[0].bad    <= bad_s4 || bad1 || bad2;
		end
	end

	// seven log units in parallel, side data delayed alongside
	logic [LNW-1:0] ln_o [NLN];

	for (genvar g = 0; g < NLN; g++) begin : g_ln
		nplc_ln #(
			.XW        (XW),
			.FRAC_BITS (FRAC_BITS)
		) u_ln (
			.clk (clk),
			.en  (en),
			.x   (lnx_s5[g]),
			.ln  (ln_o[g])
		);
	end

	for (genvar k = 0; k < LN_LAT; k++) begin : g_sd
		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[k+1] <= sd_s[k];
			end
		end
	end

	// log-ratio sums
	logic signed [LSW-1:0] lx [NLN];
	logic signed [LSW-1:0] l_s6 [4];
	logic [XW-1:0]         n_s6 [4];
	logic                  bad_s6;

	always_comb begin
		for (int i = 0; i < NLN; i++) begin
			lx[i] = LSW'(ln_o[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s6[0] <= lx[LX_ND] + lx[LX_NBC] - lx[LX_NBT] - lx[LX_AUG];
			l_s6[1] <= sd_s[LN_LAT].bcnz ?
				lx[LX_NBC] - lx[LX_NBT] - lx[LX_BC] + lx[LX_BT] : '0;
			l_s6[2] <= lx[LX_ND] - lx[LX_NBT] - lx[LX_D] + lx[LX_BT];
			l_s6[3] <= lx[LX_BT] - lx[LX_NBT];
			n_s6[0] <= sd_s[LN_LAT].aug;
			n_s6[1] <= XW'(sd_s[LN_LAT].ao);
			n_s6[2] <= XW'(sd_s[LN_LAT].bcnt);
			n_s6[3] <= XW'(sd_s[LN_LAT].cc);
			bad_s6  <= sd_s[LN_LAT].bad;
		end
	end

	// magnitude and sign
	logic [LSW-1:0] mag_s7 [4];
	logic           neg_s7 [4];
	logic [XW-1:0]  n_s7   [4];
	logic           bad_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				neg_s7[j] <= l_s6[j][LSW-1];
				mag_s7[j] <= l_s6[j][LSW-1] ? LSW'(-l_s6[j]) : LSW'(l_s6[j]);
				n_s7[j]   <= n_s6[j];
			end
			bad_s7 <= bad_s6;
		end
	end

	// count times log ratio, split in two partial products
	logic [NLO+LSW-1:0] plo_s8 [4];
	logic [NHI+LSW-1:0] phi_s8 [4];
	logic               neg_s8 [4];
	logic               bad_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				plo_s8[j] <= (NLO+LSW)'(n_s7[j][NLO-1:0]) * (NLO+LSW)'(mag_s7[j]);
				phi_s8[j] <= (NHI+LSW)'(n_s7[j][XW-1:NLO]) * (NHI+LSW)'(mag_s7[j]);
				neg_s8[j] <= neg_s7[j];
			end
			bad_s8 <= bad_s7;
		end
	end

	// product assembly with rounding
	logic [PW2-1:0] p_s9   [4];
	logic           neg_s9 [4];
	logic           bad_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				p_s9[j]   <= PW2'(plo_s8[j]) + (PW2'(phi_s8[j]) << NLO) +
					(PW2'(1) << (LF - 1));
				neg_s9[j] <= neg_s8[j];
			end
			bad_s9 <= bad_s8;
		end
	end

	// scale, cap and sign each term
	logic [EXW-1:0]       qx  [4];
	logic [TW-2:0]        v   [4];
	logic signed [TW-1:0] term_s10 [4];
	logic                 bad_s10;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			qx[j] = EXW'(p_s9[j][PW2-1:LF]);
			v[j]  = (qx[j] > EXW'(CAPV)) ? CAPV : qx[j][TW-2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				term_s10[j] <= neg_s9[j] ? -$signed({1'b0, v[j]}) : $signed({1'b0, v[j]});
			end
			bad_s10 <= bad_s9;
		end
	end

	// pairwise sums
	logic signed [SW-1:0] s01_s11, s23_s11;
	logic                 bad_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			s01_s11 <= SW'(term_s10[0]) + SW'(term_s10[1]);
			s23_s11 <= SW'(term_s10[2]) + SW'(term_s10[3]);
			bad_s11 <= bad_s10;
		end
	end

	// final sum, saturation, error forcing
	logic signed [SW-1:0]       tot;
	logic signed [OUT_BITS-1:0] sat;
	logic signed [OUT_BITS-1:0] chg_s12;
	logic                       bad_s12;

	always_comb begin
		tot = s01_s11 + s23_s11;
		priority if (!tot[SW-1] && (tot[SW-2:OUT_BITS-1] != '0)) begin
			sat = {1'b0, {(OUT_BITS-1){1'b1}}};
		end else if (tot[SW-1] && (tot[SW-2:OUT_BITS-1] != '1)) begin
			sat = {1'b1, {(OUT_BITS-1){1'b0}}};
		end else begin
			sat = tot[OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chg_s12 <= bad_s11 ? '0 : sat;
			bad_s12 <= bad_s11;
		end
	end

	// threshold test into the output register
	logic signed [OUT_BITS:0] marg;
	logic                     prune_c;

	assign marg    = (OUT_BITS+1)'(chg_s12) + $signed({(OUT_BITS+1-THR_BITS)'(0), thr_q});
	assign prune_c = !bad_s12 && !marg[OUT_BITS] && (marg != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ol) begin
			ov_q <= vp_q[P-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ol) begin
			m_axis_tdata <= ODW'({bad_s12, prune_c, chg_s12});
		end
	end

	assign m_axis_tvalid = ov_q;

endmodule

`default_nettype wire
